// ===== hdl/bbat_pkg.sv =====
`timescale 1ns / 1ps
package bbat_pkg;

  // Default widths: Q16.16 coordinates, Q4.12 weights
  localparam int COORD_W_DEF  = 32;
  localparam int WEIGHT_W_DEF = 16;

  // Integer bits of a weight; the rest are fraction bits
  localparam int WEIGHT_INT = 4;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [2:0] CFG_WX = 3'd0;
  localparam logic [2:0] CFG_WY = 3'd1;
  localparam logic [2:0] CFG_WZ = 3'd2;
  localparam logic [2:0] CFG_OX = 3'd3;
  localparam logic [2:0] CFG_OY = 3'd4;
  localparam logic [2:0] CFG_OZ = 3'd5;

  // Classified request kinds; hold reports the box untouched
  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_ADD   = 2'd1,
    OP_XFORM = 2'd2,
    OP_HOLD  = 2'd3
  } op_e;

endpackage

// ===== hdl/bbat_front.sv =====
`timescale 1ns / 1ps
module bbat_front import bbat_pkg::*; #(
  parameter int COORD_W = COORD_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_kind_i,
  input  logic [3*COORD_W-1:0] in_point_i,
  output logic                 q_valid_o,
  output op_e                  q_op_o,
  output logic [3*COORD_W-1:0] q_point_o,
  input  logic                 q_pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    op_e                  op;
    logic [3*COORD_W-1:0] point;
  } entry_t;

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  op_e              op_in;
  logic             push, pop;

  // Classify the request kind
  always_comb begin
    case (in_kind_i)
      2'd0:    op_in = OP_RESET;
      2'd1:    op_in = OP_ADD;
      2'd2:    op_in = OP_XFORM;
      default: op_in = OP_HOLD;
    endcase
  end

  assign in_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_op_o     = mem_q[rd_ptr_q].op;
  assign q_point_o  = mem_q[rd_ptr_q].point;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: op_in, point: in_point_i};
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/bbat_back.sv =====
`timescale 1ns / 1ps
module bbat_back import bbat_pkg::*; #(
  parameter int COORD_W  = COORD_W_DEF,
  parameter int WEIGHT_W = WEIGHT_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  op_e                   q_op_i,
  input  logic [3*COORD_W-1:0]  q_point_i,
  output logic                  q_pop_o,
  input  logic [3*WEIGHT_W-1:0] weights_i [3],
  input  logic [COORD_W-1:0]    offset_i [3],
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [6*COORD_W-1:0]  out_box_o,
  output logic                  out_empty_o
);

  localparam int FRAC = WEIGHT_W - WEIGHT_INT;
  localparam int PW   = COORD_W + WEIGHT_W;
  localparam int AW   = COORD_W + WEIGHT_W + 3;
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XF,
    ST_WR
  } state_e;

  function automatic logic signed [COORD_W-1:0] clamp(input logic signed [AW-1:0] v);
    if (v > AW'(CMAX))      return CMAX;
    else if (v < AW'(CMIN)) return CMIN;
    else                    return v[COORD_W-1:0];
  endfunction

  state_e                      state_q;
  logic signed [COORD_W-1:0]   lo_q [3], hi_q [3], nlo_q [3], nhi_q [3];
  logic signed [COORD_W-1:0]   lo_d [3], hi_d [3], lo_n [3], hi_n [3], pt [3];
  logic [1:0]                  ia_q, ik_q, m_a_q, m_k_q;
  logic                        iss_q, m_v_q;
  logic signed [PW-1:0]        pa, pb, pmin_q, pmax_q;
  logic signed [WEIGHT_W-1:0]  w_sel;
  logic signed [AW-1:0]        amin_q, amax_q, off_ext, sum_min, sum_max;
  logic signed [COORD_W-1:0]   out_lo_q [3], out_hi_q [3];
  logic                        out_v_q, out_e_q;
  logic                        empty, out_free, idle_go, start_xf, direct_load, commit, out_load;

  assign empty    = lo_q[0] > hi_q[0];
  assign out_free = !out_v_q || out_ready_i;
  assign idle_go  = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign start_xf = idle_go && (q_op_i == OP_XFORM) && !empty;
  assign direct_load = idle_go && !start_xf;
  assign commit   = (state_q == ST_WR) && out_free;
  assign out_load = direct_load || commit;
  assign q_pop_o  = idle_go;

  // Direct requests: empty, widen, or leave the box
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]   = q_point_i[i*COORD_W +: COORD_W];
      lo_d[i] = lo_q[i];
      hi_d[i] = hi_q[i];
      case (q_op_i)
        OP_RESET: begin
          lo_d[i] = CMAX;
          hi_d[i] = CMIN;
        end
        OP_ADD: begin
          if (pt[i] < lo_q[i]) lo_d[i] = pt[i];
          if (pt[i] > hi_q[i]) hi_d[i] = pt[i];
        end
        default: ;
      endcase
      lo_n[i] = commit ? nlo_q[i] : lo_d[i];
      hi_n[i] = commit ? nhi_q[i] : hi_d[i];
    end
  end

  // Transform products: one weight against both bounds of one input axis
  assign w_sel = weights_i[ia_q][ik_q*WEIGHT_W +: WEIGHT_W];
  assign pa    = w_sel * lo_q[ik_q];
  assign pb    = w_sel * hi_q[ik_q];

  // Separable min/max of the affine sum, offset seeded on the first term
  assign off_ext = AW'($signed(offset_i[m_a_q])) <<< FRAC;
  assign sum_min = ((m_k_q == 2'd0) ? off_ext : amin_q) + AW'(pmin_q);
  assign sum_max = ((m_k_q == 2'd0) ? off_ext : amax_q) + AW'(pmax_q);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pmin_q <= (pa < pb) ? pa : pb;
    pmax_q <= (pa < pb) ? pb : pa;
    m_a_q  <= ia_q;
    m_k_q  <= ik_q;
    if (m_v_q) begin
      amin_q <= sum_min;
      amax_q <= sum_max;
      if (m_k_q == 2'd2) begin
        nlo_q[m_a_q] <= clamp(sum_min >>> FRAC);
        nhi_q[m_a_q] <= clamp(sum_max >>> FRAC);
      end
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_lo_q[i] <= lo_n[i];
        out_hi_q[i] <= hi_n[i];
      end
      out_e_q <= lo_n[0] > hi_n[0];
    end
  end

  // Control, box state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q   <= 1'b0;
      ia_q    <= '0;
      ik_q    <= '0;
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= CMAX;
        hi_q[i] <= CMIN;
      end
    end else begin
      m_v_q <= iss_q;
      if (start_xf) begin
        state_q <= ST_XF;
        iss_q   <= 1'b1;
        ia_q    <= '0;
        ik_q    <= '0;
      end else if (iss_q) begin
        if (ik_q == 2'd2) begin
          ik_q <= '0;
          if (ia_q == 2'd2) iss_q <= 1'b0;
          else              ia_q  <= ia_q + 1'b1;
        end else begin
          ik_q <= ik_q + 1'b1;
        end
      end
      if (state_q == ST_XF && m_v_q && m_k_q == 2'd2 && m_a_q == 2'd2) state_q <= ST_WR;
      if (commit) state_q <= ST_IDLE;
      if (out_load) begin
        for (int i = 0; i < 3; i++) begin
          lo_q[i] <= lo_n[i];
          hi_q[i] <= hi_n[i];
        end
      end
      if (out_load)         out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_empty_o = out_e_q;
  assign out_box_o   = {out_hi_q[2], out_hi_q[1], out_hi_q[0],
                        out_lo_q[2], out_lo_q[1], out_lo_q[0]};

  // The box holds still while the bounds are being transformed
  a_xf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XF) |=> ($stable(lo_q[0]) && $stable(hi_q[2])))
    else $error("box changed during transform");

  // Requests leave the queue only when the sequencer is free
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && !iss_q && !m_v_q))
    else $error("pop while transform busy");

  // A result is never loaded over one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |-> !out_load)
    else $error("result overwritten");

  // A box that is not empty is ordered on every axis
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2]))
    else $error("box bounds out of order");

endmodule

// ===== hdl/bounding_box_accumulate_transform_top.sv =====
`timescale 1ns / 1ps
// Axis-aligned 3D bounding box with affine transform, fixed point.
// Slave stream carries requests: tuser is the kind (empty, add point,
// transform, other codes report the box), tdata the point x, y, z.
// Master stream returns one result per request: tdata the box
// min x, y, z then max x, y, z; tuser the empty flag.
// The configuration channel writes the packed Q4.12 weight rows and the
// Q16.16 offsets; it is always ready. The user must write it only while
// idle; the block does not enforce this. Empty, add-point and hold
// requests run directly in the back end, one per cycle while the result
// register is free. A transform takes a start step, 9 weight steps on a
// shared pair of multipliers, one accumulate stage and a commit once the
// result register is free. A 4-entry request queue separates intake
// from execution; the back end takes no request while a result waits.
// When the receiver stalls, the result holds and the queue fills, then
// s_axis_tready drops. Reset empties the box and restores identity
// weights with zero offset; no clearing pass is needed.
module bounding_box_accumulate_transform_top import bbat_pkg::*; #(
  parameter int COORD_W  = COORD_W_DEF,
  parameter int WEIGHT_W = WEIGHT_W_DEF,
  localparam int CFG_W   = (3 * WEIGHT_W > COORD_W) ? 3 * WEIGHT_W : COORD_W,
  localparam int TDI_W   = ((3 * COORD_W + 7) / 8) * 8,
  localparam int TDO_W   = ((6 * COORD_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [TDI_W-1:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic [1:0]       s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [TDO_W-1:0] m_axis_tdata,   // min x,y,z, max x,y,z
  output logic [0:0]       m_axis_tuser,   // box_empty
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int FRAC = WEIGHT_W - WEIGHT_INT;

  logic [3*WEIGHT_W-1:0] weights_q [3];
  logic [COORD_W-1:0]    offset_q [3];
  logic                  q_valid, q_pop;
  op_e                   q_op;
  logic [3*COORD_W-1:0]  q_point;
  logic [6*COORD_W-1:0]  box;
  logic                  box_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q[0] <= (3*WEIGHT_W)'(1) << FRAC;
      weights_q[1] <= (3*WEIGHT_W)'(1) << (FRAC + WEIGHT_W);
      weights_q[2] <= (3*WEIGHT_W)'(1) << (FRAC + 2 * WEIGHT_W);
      for (int i = 0; i < 3; i++) offset_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WX:  weights_q[0] <= cfg_data_i[3*WEIGHT_W-1:0];
        CFG_WY:  weights_q[1] <= cfg_data_i[3*WEIGHT_W-1:0];
        CFG_WZ:  weights_q[2] <= cfg_data_i[3*WEIGHT_W-1:0];
        CFG_OX:  offset_q[0]  <= cfg_data_i[COORD_W-1:0];
        CFG_OY:  offset_q[1]  <= cfg_data_i[COORD_W-1:0];
        CFG_OZ:  offset_q[2]  <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  bbat_front #(
    .COORD_W (COORD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_point_i (s_axis_tdata[3*COORD_W-1:0]),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .q_point_o  (q_point),
    .q_pop_i    (q_pop)
  );

  bbat_back #(
    .COORD_W  (COORD_W),
    .WEIGHT_W (WEIGHT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_point_i   (q_point),
    .q_pop_o     (q_pop),
    .weights_i   (weights_q),
    .offset_i    (offset_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_box_o   (box),
    .out_empty_o (box_empty)
  );

  assign m_axis_tdata = TDO_W'(box);
  assign m_axis_tuser = box_empty;

endmodule

// ===== tb/sv/bounding_box_accumulate_transform_top_tb.sv =====
`timescale 1ns / 1ps
module bounding_box_accumulate_transform_top_tb;
  import bbat_pkg::*;

  localparam int CW = 32;
  localparam int WW = 16;
  localparam int WFRAC = WW - WEIGHT_INT;
  localparam int CFGW = 48;
  localparam logic signed [63:0] CMAX = 64'sd2147483647;
  localparam logic signed [63:0] CMIN = -64'sd2147483648;

  typedef struct packed {
    logic [CW-1:0] lx, ly, lz, hx, hy, hz;
    logic          empty;
  } box_t;

  // Box predictor and queue of expected results
  class box_scoreboard;
    logic [CFGW-1:0] wrow[3];
    logic signed [63:0] offs[3];
    logic signed [63:0] lo[3], hi[3];
    box_t pending[$];
    int errors;

    function new();
      wrow[0] = 48'd1 << WFRAC;
      wrow[1] = 48'd1 << (WFRAC + WW);
      wrow[2] = 48'd1 << (WFRAC + 2 * WW);
      for (int a = 0; a < 3; a++) offs[a] = 0;
      clear_box();
      errors = 0;
    endfunction

    function void clear_box();
      for (int a = 0; a < 3; a++) begin
        lo[a] = CMAX;
        hi[a] = CMIN;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFGW-1:0] v);
      case (idx)
        CFG_WX: wrow[0] = v;
        CFG_WY: wrow[1] = v;
        CFG_WZ: wrow[2] = v;
        CFG_OX: offs[0] = 64'(signed'(v[CW-1:0]));
        CFG_OY: offs[1] = 64'(signed'(v[CW-1:0]));
        CFG_OZ: offs[2] = 64'(signed'(v[CW-1:0]));
        default: ;
      endcase
    endfunction

    function logic signed [63:0] map_axis(int a, logic signed [63:0] p[3]);
      logic signed [63:0] acc;
      logic signed [WW-1:0] w;
      acc = offs[a] <<< WFRAC;
      for (int k = 0; k < 3; k++) begin
        w = wrow[a][k*WW +: WW];
        acc += 64'(w) * p[k];
      end
      acc = acc >>> WFRAC;
      if (acc > CMAX) acc = CMAX;
      if (acc < CMIN) acc = CMIN;
      return acc;
    endfunction

    function void note_request(logic [1:0] kind, logic [3*CW-1:0] pt);
      logic signed [63:0] p[3], nl[3], nh[3], t;
      box_t r;
      case (op_e'(kind))
        OP_RESET: clear_box();
        OP_ADD: begin
          for (int a = 0; a < 3; a++) begin
            p[a] = 64'(signed'(pt[a*CW +: CW]));
            if (p[a] < lo[a]) lo[a] = p[a];
            if (p[a] > hi[a]) hi[a] = p[a];
          end
        end
        OP_XFORM: begin
          if (lo[0] <= hi[0]) begin
            for (int a = 0; a < 3; a++) begin
              nl[a] = CMAX;
              nh[a] = CMIN;
            end
            for (int c = 0; c < 8; c++) begin
              p[0] = c[2] ? hi[0] : lo[0];
              p[1] = c[1] ? hi[1] : lo[1];
              p[2] = c[0] ? hi[2] : lo[2];
              for (int a = 0; a < 3; a++) begin
                t = map_axis(a, p);
                if (t < nl[a]) nl[a] = t;
                if (t > nh[a]) nh[a] = t;
              end
            end
            lo = nl;
            hi = nh;
          end
        end
        default: ;
      endcase
      r.lx = lo[0][CW-1:0]; r.ly = lo[1][CW-1:0]; r.lz = lo[2][CW-1:0];
      r.hx = hi[0][CW-1:0]; r.hy = hi[1][CW-1:0]; r.hz = hi[2][CW-1:0];
      r.empty = lo[0] > hi[0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [6*CW-1:0] d, logic e);
      box_t want, got;
      got = {d[0 +: CW], d[CW +: CW], d[2*CW +: CW],
             d[3*CW +: CW], d[4*CW +: CW], d[5*CW +: CW], e};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: box mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_valid_i = 0;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready_o;
  logic [191:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic [2:0] cfg_index_i = '0;
  logic [CFGW-1:0] cfg_data_i = '0;
  bit quiet = 0;
  box_scoreboard sb = new();

  bounding_box_accumulate_transform_top dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Receiver: random stalls, none while quiet
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      m_axis_tready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Valid stays high between back-to-back requests while quiet, else random gaps occur; callers drop it
  task automatic send_request(logic [1:0] kind, logic [95:0] pt);
    while (!quiet && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pt;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, pt);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFGW-1:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
    endcase
  endfunction

  function automatic logic [95:0] rand_point();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic load_setting(int mode);
    for (int a = 0; a < 3; a++)
      write_reg(CFG_WX + 3'(a), mode == 0 ? 48'h7fff7fff7fff :
                mode == 1 ? 48'h800080008000 :
                {rand_weight(), rand_weight(), rand_weight()});
    for (int a = 0; a < 3; a++)
      write_reg(CFG_OX + 3'(a), mode == 0 ? 48'h7fffffff :
                mode == 1 ? 48'h80000000 : 48'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: identity transform, empty-box cases, extremes, unused code
    send_request(OP_XFORM, '0);
    send_request(OP_HOLD, '1);
    send_request(OP_ADD, {32'h7fffffff, 32'h80000000, 32'h00010000});
    send_request(OP_ADD, {32'h80000000, 32'h7fffffff, 32'hffff0000});
    send_request(OP_HOLD, '0);
    send_request(OP_XFORM, '0);
    send_request(OP_RESET, '1);
    send_request(OP_ADD, {32'h00030000, 32'hfffe8000, 32'h00001234});
    send_request(OP_XFORM, '0);
    wait_drain();
    for (int m = 0; m < 2; m++) begin
      load_setting(m);
      send_request(OP_ADD, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
      send_request(OP_ADD, {32'h80000000, 32'h80000000, 32'h80000000});
      send_request(OP_XFORM, '0);
      send_request(OP_RESET, '0);
      send_request(OP_ADD, {32'h00020000, 32'hffff0000, 32'h00008000});
      send_request(OP_XFORM, '0);
      wait_drain();
    end
    // Random phases: runs of adds, occasional transforms, holds and resets
    for (int ph = 0; ph < 10; ph++) begin
      load_setting(2);
      quiet = (ph == 4);
      for (int i = 0; i < 75; i++) begin
        case ($urandom_range(19))
          0: send_request(OP_RESET, rand_point());
          1, 2: send_request(OP_XFORM, rand_point());
          3: send_request(OP_HOLD, rand_point());
          default: send_request(OP_ADD, rand_point());
        endcase
        if (i == 40) begin
          s_axis_tvalid <= 0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
      end
      quiet = 0;
      wait_drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
